// ===== rtl/hbc_pkg.sv =====
// ----------------------------------------------------------------------------
// hbc_pkg
// shared types, request codes and defaults of the history buffer with cursor
// ----------------------------------------------------------------------------
package hbc_pkg;

  localparam int CAPACITY_DEF = 100;
  localparam int SEQ_W        = 64;

  localparam logic [2:0] REQ_APPEND = 3'd0;
  localparam logic [2:0] REQ_BACK   = 3'd1;
  localparam logic [2:0] REQ_FWD    = 3'd2;
  localparam logic [2:0] REQ_OLDEST = 3'd3;
  localparam logic [2:0] REQ_NEWEST = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [1:0]  entry_kind;
    logic [31:0] entry_payload;
    logic        speak_now;
  } hbc_in_t;

  typedef struct packed {
    logic [31:0] say_payload;
    logic        log_empty;
  } hbc_out_t;

  typedef struct packed {
    logic [31:0] payload;
    logic [1:0]  kind;
  } hbc_entry_t;

  typedef struct packed {
    logic        valid;
    logic        from_store;
    logic        empty;
    logic [31:0] payload;
  } hbc_res_t;

endpackage

// ===== rtl/hbc_in_stage.sv =====
// ----------------------------------------------------------------------------
// hbc_in_stage
// input register that holds one request word for the processing cycle
// ----------------------------------------------------------------------------
module hbc_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  hbc_pkg::hbc_in_t in_data,
  input  logic            adv,
  output logic            item_valid,
  output hbc_pkg::hbc_in_t item
);

  logic             valid_r;
  logic             valid_nxt;
  hbc_pkg::hbc_in_t data_r;

  assign in_ready   = !valid_r || adv;
  assign item_valid = valid_r;
  assign item       = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

// ===== rtl/hbc_core.sv =====
// ----------------------------------------------------------------------------
// hbc_core
// entry store, ring pointers, sequence numbers and cursor update
// ----------------------------------------------------------------------------
module hbc_core #(
  parameter int CAPACITY = hbc_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               proc_en,
  input  logic               adv,
  input  hbc_pkg::hbc_in_t   item,
  output hbc_pkg::hbc_res_t  res_nxt,
  output hbc_pkg::hbc_entry_t rd_entry
);

  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int SEQ_W  = hbc_pkg::SEQ_W;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SLOT_W-1:0] oldest_slot_r, oldest_slot_nxt;
  logic [SEQ_W-1:0]  oldest_seq_r, oldest_seq_nxt;
  logic [SEQ_W-1:0]  cursor_r, cursor_nxt;
  logic              follow_r, follow_nxt;

  hbc_pkg::hbc_entry_t store [CAPACITY];
  hbc_pkg::hbc_entry_t rd_entry_r;

  logic              full;
  logic              empty;
  logic [SLOT_W-1:0] last;
  logic [SEQ_W-1:0]  cur_gap;
  logic              in_range;
  logic [SLOT_W-1:0] cur;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W:0]   rd_sum;
  logic [SLOT_W-1:0] rd_slot;
  logic [SLOT_W:0]   wr_sum;
  logic [SLOT_W-1:0] wr_slot;
  logic [SLOT_W-1:0] slot_inc;
  logic              is_append;
  logic              is_move;
  logic              wr_en;

  assign full     = count_r == CNT_W'(CAPACITY);
  assign empty    = count_r == '0;
  assign last     = SLOT_W'(count_r - CNT_W'(1));
  assign cur_gap  = cursor_r - oldest_seq_r;
  assign in_range = cur_gap < SEQ_W'(count_r);
  assign cur      = follow_r ? last : (in_range ? cur_gap[SLOT_W-1:0] : '0);

  always_comb begin
    unique case (item.req_type)
      hbc_pkg::REQ_BACK:   idx = (cur == '0) ? '0 : cur - SLOT_W'(1);
      hbc_pkg::REQ_FWD:    idx = (cur == last) ? last : cur + SLOT_W'(1);
      hbc_pkg::REQ_OLDEST: idx = '0;
      default:             idx = last;
    endcase
  end

  // ring slot of the landed index and of the next free entry
  assign rd_sum   = {1'b0, oldest_slot_r} + {1'b0, idx};
  assign rd_slot  = (rd_sum >= (SLOT_W+1)'(CAPACITY)) ?
                    SLOT_W'(rd_sum - (SLOT_W+1)'(CAPACITY)) : rd_sum[SLOT_W-1:0];
  assign wr_sum   = {1'b0, oldest_slot_r} + {1'b0, count_r[SLOT_W-1:0]};
  assign wr_slot  = full ? oldest_slot_r :
                    ((wr_sum >= (SLOT_W+1)'(CAPACITY)) ?
                     SLOT_W'(wr_sum - (SLOT_W+1)'(CAPACITY)) : wr_sum[SLOT_W-1:0]);
  assign slot_inc = (oldest_slot_r == SLOT_W'(CAPACITY - 1)) ? '0 :
                    oldest_slot_r + SLOT_W'(1);

  assign is_append = (item.req_type == hbc_pkg::REQ_APPEND) && (item.entry_payload != '0);
  assign is_move   = (item.req_type == hbc_pkg::REQ_BACK) ||
                     (item.req_type == hbc_pkg::REQ_FWD) ||
                     (item.req_type == hbc_pkg::REQ_OLDEST) ||
                     (item.req_type == hbc_pkg::REQ_NEWEST);
  assign wr_en     = proc_en && is_append;

  always_comb begin
    count_nxt       = count_r;
    oldest_slot_nxt = oldest_slot_r;
    oldest_seq_nxt  = oldest_seq_r;
    cursor_nxt      = cursor_r;
    follow_nxt      = follow_r;
    res_nxt         = '0;
    if (proc_en && is_append) begin
      if (full) begin
        oldest_slot_nxt = slot_inc;
        oldest_seq_nxt  = oldest_seq_r + SEQ_W'(1);
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
      if (follow_r) begin
        cursor_nxt = oldest_seq_r + SEQ_W'(count_r);
      end
      res_nxt.valid   = item.speak_now;
      res_nxt.payload = item.entry_payload;
    end else if (proc_en && is_move) begin
      res_nxt.valid = 1'b1;
      if (empty) begin
        res_nxt.empty = 1'b1;
      end else begin
        res_nxt.from_store = 1'b1;
        cursor_nxt         = oldest_seq_r + SEQ_W'(idx);
        follow_nxt         = idx == last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      oldest_slot_r <= '0;
      oldest_seq_r  <= SEQ_W'(1);
      cursor_r      <= '0;
      follow_r      <= 1'b1;
    end else begin
      count_r       <= count_nxt;
      oldest_slot_r <= oldest_slot_nxt;
      oldest_seq_r  <= oldest_seq_nxt;
      cursor_r      <= cursor_nxt;
      follow_r      <= follow_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_slot] <= '{payload: item.entry_payload, kind: item.entry_kind};
    end
    if (adv) begin
      rd_entry_r <= store[rd_slot];
    end
  end

  assign rd_entry = rd_entry_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, oldest_slot_r} < (SLOT_W+1)'(CAPACITY))
    else $error("oldest slot out of range");

  a_follow_newest: assert property (@(posedge clk) disable iff (!rst_n)
    (follow_r && !empty) |-> (cursor_r == oldest_seq_r + SEQ_W'(count_r) - SEQ_W'(1)))
    else $error("following cursor not on newest entry");

  a_append_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_en && is_append) |=> (count_r != '0))
    else $error("store empty after append");

  a_full_evicts: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_en && is_append && full) |=> (oldest_seq_r == $past(oldest_seq_r) + SEQ_W'(1)))
    else $error("append on full store did not evict");

endmodule

// ===== rtl/hbc_out_stage.sv =====
// ----------------------------------------------------------------------------
// hbc_out_stage
// result register; picks the store read word or the direct payload
// ----------------------------------------------------------------------------
module hbc_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  hbc_pkg::hbc_res_t   res_nxt,
  input  hbc_pkg::hbc_entry_t rd_entry,
  output logic                adv,
  output logic                out_valid,
  input  logic                out_ready,
  output hbc_pkg::hbc_out_t   out_data
);

  logic        valid_r;
  logic        from_store_r;
  logic        empty_r;
  logic [31:0] payload_r;

  assign adv       = !valid_r || out_ready;
  assign out_valid = valid_r;

  always_comb begin
    out_data.say_payload = from_store_r ? rd_entry.payload : payload_r;
    out_data.log_empty   = empty_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= res_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      from_store_r <= res_nxt.from_store;
      empty_r      <= res_nxt.empty;
      payload_r    <= res_nxt.payload;
    end
  end

endmodule

// ===== rtl/history_buffer_with_cursor.sv =====
// ----------------------------------------------------------------------------
// history_buffer_with_cursor
// bounded message history with a sequence-numbered read cursor
// ----------------------------------------------------------------------------
//   channel   ports                          word
//   request   in_valid  in_ready  in_data    hbc_in_t
//   result    out_valid out_ready out_data   hbc_out_t
//
// one request word per cycle; a result word is offered once its request has
// passed the input and result registers; the result register and store read
// port load together; reset clears count, pointers and cursor; the store
// needs no clearing; a stalled result holds the whole pipe; in_ready drops
// only when both the input and result registers are full and out_ready is low
// ----------------------------------------------------------------------------
module history_buffer_with_cursor #(
  parameter int CAPACITY = hbc_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hbc_pkg::hbc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hbc_pkg::hbc_out_t out_data
);

  logic                adv;
  logic                item_valid;
  hbc_pkg::hbc_in_t    item;
  hbc_pkg::hbc_res_t   res_nxt;
  hbc_pkg::hbc_entry_t rd_entry;

  hbc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  hbc_core #(
    .CAPACITY (CAPACITY)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .proc_en  (item_valid && adv),
    .adv      (adv),
    .item     (item),
    .res_nxt  (res_nxt),
    .rd_entry (rd_entry)
  );

  hbc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_nxt   (res_nxt),
    .rd_entry  (rd_entry),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the message history buffer: appends with eviction, the
// sequence-numbered read cursor, clamped moves and empty-log notices;
// a model of the history predicts every result word, and a checker
// compares each one field by field, under random idling and output hold-off
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CAP           = hbc_pkg::CAPACITY_DEF;
  localparam int HOLD_CYCLES   = 80;
  localparam int WATCHDOG_MAX  = 1000;
  localparam int IDLE_PCT      = 16;
  localparam logic [2:0] REQ_SPARE_A = 3'd5;
  localparam logic [2:0] REQ_SPARE_B = 3'd6;
  localparam logic [2:0] REQ_SPARE_C = 3'd7;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  hbc_pkg::hbc_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  hbc_pkg::hbc_out_t out_data;

  // model of the history
  hbc_pkg::hbc_entry_t hist_mem [CAP];
  int unsigned         hist_oldest;
  int unsigned         hist_count;
  logic [63:0]         seq_next;
  logic [63:0]         cursor_seq;
  bit                  follow_newest;
  hbc_pkg::hbc_out_t   pending_says[$];
  hbc_pkg::hbc_out_t   want_word;

  int err_count;
  int n_words;
  int n_results;
  int n_empty;
  int n_evictions;
  int n_in_stall;
  int quiet_cycles;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int hold_seen;
  int hold_left;

  history_buffer_with_cursor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_expected(hbc_pkg::hbc_out_t s);
    pending_says = {pending_says, s};
  endfunction

  function automatic void track_history(hbc_pkg::hbc_in_t w);
    int unsigned       slot;
    int                last;
    int                cur;
    int                idx;
    logic [63:0]       base_seq;
    logic [63:0]       gap_seq;
    hbc_pkg::hbc_out_t say;
    say = '0;
    if (w.req_type == hbc_pkg::REQ_APPEND) begin
      if (w.entry_payload == '0) return;
      if (hist_count >= CAP) begin
        hist_oldest = (hist_oldest + 1) % CAP;
        hist_count  = CAP - 1;
        n_evictions++;
      end
      slot = (hist_oldest + hist_count) % CAP;
      hist_mem[slot].payload = w.entry_payload;
      hist_mem[slot].kind    = w.entry_kind;
      hist_count++;
      if (follow_newest) cursor_seq = seq_next;
      seq_next = seq_next + 64'd1;
      if (w.speak_now) begin
        say.say_payload = w.entry_payload;
        add_expected(say);
      end
    end else if (w.req_type >= hbc_pkg::REQ_BACK && w.req_type <= hbc_pkg::REQ_NEWEST) begin
      if (hist_count == 0) begin
        say.log_empty = 1'b1;
        add_expected(say);
        return;
      end
      last     = int'(hist_count) - 1;
      base_seq = seq_next - 64'(hist_count);
      if (w.req_type == hbc_pkg::REQ_OLDEST) idx = 0;
      else if (w.req_type == hbc_pkg::REQ_NEWEST) idx = last;
      else begin
        if (follow_newest) cur = last;
        else begin
          // cursor entry gone: start from the oldest one
          gap_seq = cursor_seq - base_seq;
          cur     = (gap_seq < 64'(hist_count)) ? int'(gap_seq) : 0;
        end
        idx = (w.req_type == hbc_pkg::REQ_BACK) ? cur - 1 : cur + 1;
      end
      if (idx < 0) idx = 0;
      if (idx > last) idx = last;
      slot          = (hist_oldest + idx) % CAP;
      cursor_seq    = base_seq + 64'(idx);
      follow_newest = (idx == last);
      say.say_payload = hist_mem[slot].payload;
      add_expected(say);
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    err_count++;
  endtask

  // result check first, then the word accepted at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_says.size() == 0) begin
          flag_mismatch("unexpected result word", out_data.say_payload, '0);
        end else begin
          want_word = pending_says.pop_front();
          if (want_word.log_empty) n_empty++;
          if (out_data.say_payload !== want_word.say_payload)
            flag_mismatch("say_payload", out_data.say_payload, want_word.say_payload);
          if (out_data.log_empty !== want_word.log_empty)
            flag_mismatch("log_empty", 32'(out_data.log_empty), 32'(want_word.log_empty));
        end
      end
      if (in_valid && in_ready) begin
        n_words++;
        track_history(in_data);
      end
      if (in_valid && !in_ready) n_in_stall++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("%0t watchdog: no word moved for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic hbc_pkg::hbc_in_t make_word(input logic [2:0] req,
                                                 input logic [1:0] kind,
                                                 input logic [31:0] payload,
                                                 input logic speak);
    hbc_pkg::hbc_in_t w;
    w.req_type      = req;
    w.entry_kind    = kind;
    w.entry_payload = payload;
    w.speak_now     = speak;
    return w;
  endfunction

  function automatic hbc_pkg::hbc_in_t random_word();
    hbc_pkg::hbc_in_t w;
    int unsigned      pick;
    w.entry_kind = 2'($urandom_range(3));
    w.speak_now  = 1'($urandom_range(1));
    case ($urandom_range(15))
      0:       w.entry_payload = '0;
      1:       w.entry_payload = 32'hFFFF_FFFF;
      2:       w.entry_payload = 32'($urandom_range(8, 1));
      default: w.entry_payload = $urandom;
    endcase
    pick = $urandom_range(99);
    if (pick < 44) w.req_type = hbc_pkg::REQ_APPEND;
    else if (pick < 58) w.req_type = hbc_pkg::REQ_BACK;
    else if (pick < 72) w.req_type = hbc_pkg::REQ_FWD;
    else if (pick < 81) w.req_type = hbc_pkg::REQ_OLDEST;
    else if (pick < 93) w.req_type = hbc_pkg::REQ_NEWEST;
    else begin
      case ($urandom_range(2))
        0:       w.req_type = REQ_SPARE_A;
        1:       w.req_type = REQ_SPARE_B;
        default: w.req_type = REQ_SPARE_C;
      endcase
    end
    return w;
  endfunction

  task automatic send_word(input hbc_pkg::hbc_in_t w);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic test_empty_store();
    send_word(make_word(hbc_pkg::REQ_BACK, 2'd0, 32'h0, 1'b0));
    send_word(make_word(hbc_pkg::REQ_FWD, 2'd3, 32'hFFFF_FFFF, 1'b1));
    send_word(make_word(hbc_pkg::REQ_OLDEST, 2'd1, 32'h0, 1'b0));
    send_word(make_word(hbc_pkg::REQ_NEWEST, 2'd2, 32'h0, 1'b1));
    // empty text is dropped even when spoken
    send_word(make_word(hbc_pkg::REQ_APPEND, 2'd2, 32'h0, 1'b1));
    send_word(make_word(REQ_SPARE_A, 2'd0, 32'h1234_5678, 1'b1));
    send_word(make_word(hbc_pkg::REQ_BACK, 2'd0, 32'h0, 1'b0));
  endtask

  task automatic test_append_extremes();
    send_word(make_word(hbc_pkg::REQ_APPEND, 2'd0, 32'h0000_0001, 1'b1));
    send_word(make_word(hbc_pkg::REQ_APPEND, 2'd3, 32'hFFFF_FFFF, 1'b1));
    send_word(make_word(hbc_pkg::REQ_APPEND, 2'd1, 32'h5A5A_5A5A, 1'b0));
    send_word(make_word(REQ_SPARE_B, 2'd3, 32'hA5A5_A5A5, 1'b1));
    send_word(make_word(hbc_pkg::REQ_APPEND, 2'd2, 32'h8000_0000, 1'b0));
    send_word(make_word(REQ_SPARE_C, 2'd1, 32'hFFFF_FFFF, 1'b0));
  endtask

  task automatic test_cursor_moves();
    send_word(make_word(hbc_pkg::REQ_NEWEST, 2'd0, 32'h0, 1'b0));
    repeat (4) send_word(make_word(hbc_pkg::REQ_BACK, 2'd0, 32'h0, 1'b0));
    send_word(make_word(hbc_pkg::REQ_FWD, 2'd0, 32'h0, 1'b0));
    send_word(make_word(hbc_pkg::REQ_OLDEST, 2'd0, 32'h0, 1'b0));
    // not following: cursor stays put
    send_word(make_word(hbc_pkg::REQ_APPEND, 2'd2, 32'h0000_1234, 1'b0));
    send_word(make_word(hbc_pkg::REQ_FWD, 2'd0, 32'h0, 1'b0));
    send_word(make_word(hbc_pkg::REQ_NEWEST, 2'd0, 32'h0, 1'b0));
    send_word(make_word(hbc_pkg::REQ_FWD, 2'd0, 32'h0, 1'b0));
    send_word(make_word(hbc_pkg::REQ_APPEND, 2'd1, 32'h7FFF_FFFF, 1'b1));
    send_word(make_word(hbc_pkg::REQ_BACK, 2'd0, 32'h0, 1'b0));
  endtask

  task automatic test_eviction();
    send_word(make_word(hbc_pkg::REQ_OLDEST, 2'd0, 32'h0, 1'b0));
    send_word(make_word(hbc_pkg::REQ_FWD, 2'd0, 32'h0, 1'b0));
    send_word(make_word(hbc_pkg::REQ_FWD, 2'd0, 32'h0, 1'b0));
    repeat (CAP + 10)
      send_word(make_word(hbc_pkg::REQ_APPEND, 2'($urandom_range(3)),
                          $urandom_range(32'hFFFF_FFFF, 1), 1'($urandom_range(1))));
    // cursor entry is gone by now
    send_word(make_word(hbc_pkg::REQ_BACK, 2'd0, 32'h0, 1'b0));
    send_word(make_word(hbc_pkg::REQ_FWD, 2'd0, 32'h0, 1'b0));
    send_word(make_word(hbc_pkg::REQ_FWD, 2'd0, 32'h0, 1'b0));
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    repeat (80) send_word(random_word());
    send_idle_pct = IDLE_PCT;
    recv_idle_pct <= IDLE_PCT;
    repeat (240) send_word(random_word());
  endtask

  task automatic test_output_holdoff();
    hbc_pkg::hbc_in_t w;
    send_idle_pct = 0;
    hold_req <= hold_req + 1;
    repeat (40) begin
      w = random_word();
      if (w.req_type == hbc_pkg::REQ_APPEND) begin
        w.speak_now        = 1'b1;
        w.entry_payload[0] = 1'b1;
      end else if (w.req_type > hbc_pkg::REQ_NEWEST) begin
        w.req_type = hbc_pkg::REQ_NEWEST;
      end
      send_word(w);
    end
    send_idle_pct = IDLE_PCT;
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    err_count     = 0;
    n_words       = 0;
    n_results     = 0;
    n_empty       = 0;
    n_evictions   = 0;
    n_in_stall    = 0;
    hold_req      = 0;
    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;
    hist_oldest   = 0;
    hist_count    = 0;
    seq_next      = 64'd1;
    cursor_seq    = 64'd0;
    follow_newest = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_store();
    test_append_extremes();
    test_cursor_moves();
    test_eviction();
    test_random_traffic();
    test_output_holdoff();
    in_valid <= 1'b0;

    while (pending_says.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d request words and %0d result words (%0d empty-log), %0d evictions",
             n_words, n_results, n_empty, n_evictions);
    $display("input held off for %0d cycles by output back-pressure, %0d mismatches",
             n_in_stall, err_count);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/hbc_pkg.sv
rtl/hbc_in_stage.sv
rtl/hbc_core.sv
rtl/hbc_out_stage.sv
rtl/history_buffer_with_cursor.sv
tb/tb_top.sv
